// ----- src/escd_pkg.sv -----
`timescale 1ns / 1ps

package escd_pkg;

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'b001,
    MODE_ESC   = 3'b010,
    MODE_OCT   = 3'b100
  } mode_t;

  localparam logic [7:0] CHAR_BSL  = 8'h5C;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_SEVEN = 8'h37;
  localparam logic [7:0] CHAR_R    = 8'h72;
  localparam logic [7:0] CHAR_N    = 8'h6E;
  localparam logic [7:0] CHAR_T    = 8'h74;
  localparam logic [7:0] CHAR_F    = 8'h66;
  localparam logic [7:0] CHAR_B    = 8'h62;
  localparam logic [7:0] CHAR_E    = 8'h65;

  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_FF  = 8'h0C;
  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_ESC = 8'h1B;

  localparam logic [1:0] MAX_OCT_DIGITS = 2'd3;

  localparam int OBUF_DEPTH = 4;
  localparam int OBUF_AW    = $clog2(OBUF_DEPTH);
  localparam int OBUF_CW    = $clog2(OBUF_DEPTH + 1);

  typedef struct packed {
    logic [7:0] decoded_byte;
    logic       run_end;
    logic       text_end;
  } res_t;

  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } dec_out_t;

endpackage

// ----- src/escd_dec.sv -----
`timescale 1ns / 1ps

module escd_dec (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          text_byte,
  input  logic                is_final,
  output escd_pkg::dec_out_t  dec
);

  escd_pkg::mode_t mode_r, mode_nxt;
  logic [7:0]      oct_val_r, oct_val_nxt;
  logic [1:0]      oct_cnt_r, oct_cnt_nxt;

  logic            is_oct;
  logic [2:0]      digit;
  logic [7:0]      oct_shift;
  logic [1:0]      oct_cnt_inc;
  logic [1:0]      num;
  logic [7:0]      b0;
  logic [7:0]      b1;

  assign is_oct      = (text_byte >= escd_pkg::CHAR_ZERO) && (text_byte <= escd_pkg::CHAR_SEVEN);
  assign digit       = text_byte[2:0];
  assign oct_shift   = {oct_val_r[4:0], digit};
  assign oct_cnt_inc = oct_cnt_r + 2'd1;

  always_comb begin
    mode_nxt    = mode_r;
    oct_val_nxt = oct_val_r;
    oct_cnt_nxt = oct_cnt_r;
    num         = 2'd0;
    b0          = text_byte;
    b1          = text_byte;
    unique case (mode_r)
      escd_pkg::MODE_ESC: begin
        mode_nxt = escd_pkg::MODE_PLAIN;
        num      = 2'd1;
        priority if (text_byte == escd_pkg::CHAR_R) begin
          b0 = escd_pkg::BYTE_CR;
        end else if (text_byte == escd_pkg::CHAR_N) begin
          b0 = escd_pkg::BYTE_LF;
        end else if (text_byte == escd_pkg::CHAR_T) begin
          b0 = escd_pkg::BYTE_TAB;
        end else if (text_byte == escd_pkg::CHAR_F) begin
          b0 = escd_pkg::BYTE_FF;
        end else if (text_byte == escd_pkg::CHAR_B) begin
          b0 = escd_pkg::BYTE_BS;
        end else if (text_byte == escd_pkg::CHAR_E) begin
          b0 = escd_pkg::BYTE_ESC;
        end else if (is_oct) begin
          b0 = {5'd0, digit};
          if (!is_final) begin
            num         = 2'd0;
            oct_val_nxt = {5'd0, digit};
            oct_cnt_nxt = 2'd1;
            mode_nxt    = escd_pkg::MODE_OCT;
          end
        end else begin
          b0 = text_byte;
        end
      end
      escd_pkg::MODE_OCT: begin
        if (is_oct) begin
          if (oct_cnt_inc >= escd_pkg::MAX_OCT_DIGITS || oct_cnt_inc == 2'd0 || is_final) begin
            num         = 2'd1;
            b0          = oct_shift;
            mode_nxt    = escd_pkg::MODE_PLAIN;
            oct_val_nxt = 8'd0;
            oct_cnt_nxt = 2'd0;
          end else begin
            oct_val_nxt = oct_shift;
            oct_cnt_nxt = oct_cnt_inc;
          end
        end else begin
          b0          = oct_val_r;
          oct_val_nxt = 8'd0;
          oct_cnt_nxt = 2'd0;
          if (text_byte == escd_pkg::CHAR_BSL && !is_final) begin
            num      = 2'd1;
            mode_nxt = escd_pkg::MODE_ESC;
          end else begin
            num      = 2'd2;
            mode_nxt = escd_pkg::MODE_PLAIN;
          end
        end
      end
      default: begin
        if (text_byte == escd_pkg::CHAR_BSL && !is_final) begin
          mode_nxt = escd_pkg::MODE_ESC;
        end else begin
          num = 2'd1;
        end
      end
    endcase
    if (is_final) begin
      mode_nxt    = escd_pkg::MODE_PLAIN;
      oct_val_nxt = 8'd0;
      oct_cnt_nxt = 2'd0;
    end
  end

  always_comb begin
    dec.num             = num;
    dec.r0.decoded_byte = b0;
    dec.r0.run_end      = (num == 2'd1);
    dec.r0.text_end     = (num == 2'd1) && is_final;
    dec.r1.decoded_byte = b1;
    dec.r1.run_end      = 1'b1;
    dec.r1.text_end     = is_final;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= escd_pkg::MODE_PLAIN;
      oct_val_r <= 8'd0;
      oct_cnt_r <= 2'd0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      oct_val_r <= oct_val_nxt;
      oct_cnt_r <= oct_cnt_nxt;
    end
  end

endmodule

// ----- src/escd_obuf.sv -----
`timescale 1ns / 1ps

module escd_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  escd_pkg::dec_out_t  dec,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output escd_pkg::res_t      out_res
);

  escd_pkg::res_t mem_r [escd_pkg::OBUF_DEPTH];

  logic [escd_pkg::OBUF_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [escd_pkg::OBUF_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [escd_pkg::OBUF_CW-1:0] count_r, count_nxt;
  logic [escd_pkg::OBUF_AW-1:0] wr_ptr_p1;
  logic [escd_pkg::OBUF_CW-1:0] push_n;
  logic                         pop;

  assign pop       = out_valid && out_ready;
  assign push_n    = push ? escd_pkg::OBUF_CW'(dec.num) : '0;
  assign wr_ptr_p1 = wr_ptr_r + escd_pkg::OBUF_AW'(1);
  assign room      = count_r <= escd_pkg::OBUF_CW'(escd_pkg::OBUF_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_res   = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = wr_ptr_r + push_n[escd_pkg::OBUF_AW-1:0];
  assign rd_ptr_nxt = rd_ptr_r + escd_pkg::OBUF_AW'(pop);
  assign count_nxt  = count_r + push_n - escd_pkg::OBUF_CW'(pop);

  always_ff @(posedge clk) begin
    if (push && dec.num != 2'd0) begin
      mem_r[wr_ptr_r] <= dec.r0;
    end
    if (push && dec.num == 2'd2) begin
      mem_r[wr_ptr_p1] <= dec.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- src/escape_sequence_decoder.sv -----
`timescale 1ns / 1ps
// A decoded byte enters the output buffer when its input beat is accepted and is
// shown on out_* from there. Throughput: one input beat per cycle while in_tready
// is high; one output byte per cycle while out_tready is high. A beat may yield two
// bytes; in_tready drops while the four-entry buffer holds three or more bytes.
// Reset: synchronous active-low rst_n returns the decoder to plain text mode
// and empties the output buffer.

module escape_sequence_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  input  logic       in_tlast,   // is_final
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] decoded_byte
  output logic       out_tuser,  // run_end
  output logic       out_tlast   // text_end
);

  escd_pkg::dec_out_t dec;
  escd_pkg::res_t     res;
  logic               accept;
  logic               room;

  assign in_tready = room;
  assign accept    = in_tvalid && in_tready;

  escd_dec u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .text_byte (in_tdata),
    .is_final  (in_tlast),
    .dec       (dec)
  );

  escd_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .dec       (dec),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = res.decoded_byte;
  assign out_tuser = res.run_end;
  assign out_tlast = res.text_end;

endmodule
